>>> sv/nearest_downscale_gray_int8_core_assert.svh
// ----------------------------------------------------------------------------
// nearest_downscale_gray_int8_core assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef NEAREST_DOWNSCALE_GRAY_INT8_CORE_ASSERT_SVH
`define NEAREST_DOWNSCALE_GRAY_INT8_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define NDG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// condition must never be seen at a clock edge out of reset
`define NDG_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define NDG_ASSERT(label, clk, rst_n, prop, msg)
`define NDG_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/ndg_pkg.sv
// ----------------------------------------------------------------------------
// ndg_pkg
// Types, constants and the gray conversion of the nearest downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ndg_pkg;

	localparam int GRID_SIZE   = 96;
	localparam int SRC_W       = 11;
	localparam int SRC_MAX     = (1 << SRC_W) - 1;
	localparam int COLOR_W     = 8;
	localparam int COORD_W     = 7;
	localparam int GCNT_W      = $clog2(GRID_SIZE + 1);
	localparam int ACC_W       = $clog2(GRID_SIZE * SRC_MAX + 1);
	localparam int POS_W       = SRC_W + 1;
	localparam int PROD_W      = ACC_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [SRC_W-1:0] WIDTH_RESET  = SRC_W'(160);
	localparam logic [SRC_W-1:0] HEIGHT_RESET = SRC_W'(120);

	localparam int GRAY_W_R  = 77;
	localparam int GRAY_W_G  = 150;
	localparam int GRAY_W_B  = 29;
	localparam int GRAY_BIAS = 128;
	localparam int SUM_W     = 2 * COLOR_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 1'b0,
		REG_SOURCE_HEIGHT = 1'b1
	} ndg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               frame_start;
	} ndg_in_t;

	typedef struct packed {
		logic signed [COLOR_W-1:0] sample;
		logic [COORD_W-1:0]        out_col;
		logic [COORD_W-1:0]        out_row;
		logic                      frame_end;
	} ndg_out_t;

	// selected pixel waiting for conversion
	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} ndg_task_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ndg_qstat_t;

	function automatic logic signed [COLOR_W-1:0] to_sample(
		input logic [COLOR_W-1:0] r,
		input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] b
	);
		logic [SUM_W-1:0]   sum;
		logic [COLOR_W-1:0] gray;
		sum = SUM_W'(GRAY_W_R) * SUM_W'(r) + SUM_W'(GRAY_W_G) * SUM_W'(g)
			+ SUM_W'(GRAY_W_B) * SUM_W'(b);
		gray = sum[SUM_W-1:COLOR_W];
		return signed'(gray ^ COLOR_W'(GRAY_BIAS));
	endfunction

endpackage

>>> sv/ndg_front.sv
// ----------------------------------------------------------------------------
// ndg_front
// Tracks source and grid positions and picks the pixels that land on the grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndg_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [ndg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndg_pkg::SRC_W-1:0]   cfg_data,
	input  logic                        in_valid,
	input  ndg_pkg::ndg_in_t            in_data,
	output logic                        in_stall,
	input  ndg_pkg::ndg_qstat_t         qstat,
	output logic                        push_valid,
	output ndg_pkg::ndg_task_t          push_data
);
	import ndg_pkg::*;

	logic [SRC_W-1:0]  width_q, height_q;
	logic [SRC_W-1:0]  scol_q, srow_q;
	logic [GCNT_W-1:0] gcol_q, grow_q;
	logic [ACC_W-1:0]  cacc_q, racc_q;

	logic [SRC_W-1:0]  scol, srow;
	logic [GCNT_W-1:0] gcol, grow;
	logic [ACC_W-1:0]  cacc, racc;
	logic [POS_W-1:0]  scol_inc, srow_inc;
	logic [PROD_W-1:0] col_edge, row_edge;
	logic              accept, row_sel, col_hit, sel, row_end;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	// frame start clears the position state before the pixel is looked at
	always_comb begin
		if (in_data.frame_start) begin
			scol = '0;
			srow = '0;
			gcol = '0;
			grow = '0;
			cacc = '0;
			racc = '0;
		end else begin
			scol = scol_q;
			srow = srow_q;
			gcol = gcol_q;
			grow = grow_q;
			cacc = cacc_q;
			racc = racc_q;
		end
	end

	assign scol_inc = POS_W'(scol) + POS_W'(1);
	assign srow_inc = POS_W'(srow) + POS_W'(1);
	assign col_edge = PROD_W'(scol_inc) * PROD_W'(GRID_SIZE);
	assign row_edge = PROD_W'(srow_inc) * PROD_W'(GRID_SIZE);

	// a target that is due or overdue is served by this pixel
	assign row_sel = (grow < GCNT_W'(GRID_SIZE)) && (PROD_W'(racc) < row_edge);
	assign col_hit = (gcol < GCNT_W'(GRID_SIZE)) && (PROD_W'(cacc) < col_edge);
	assign sel     = row_sel && col_hit;
	assign row_end = scol_inc >= POS_W'(width_q);

	assign push_valid          = accept && sel;
	assign push_data.red       = in_data.red;
	assign push_data.green     = in_data.green;
	assign push_data.blue      = in_data.blue;
	assign push_data.col       = COORD_W'(gcol);
	assign push_data.row       = COORD_W'(grow);
	assign push_data.frame_end = (gcol == GCNT_W'(GRID_SIZE - 1))
		&& (grow == GCNT_W'(GRID_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (ndg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q <= '0;
			srow_q <= '0;
			gcol_q <= '0;
			grow_q <= '0;
			cacc_q <= '0;
			racc_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				scol_q <= '0;
				gcol_q <= '0;
				cacc_q <= '0;
				if (row_sel) begin
					grow_q <= grow + GCNT_W'(1);
					racc_q <= racc + ACC_W'(height_q);
				end else begin
					grow_q <= grow;
					racc_q <= racc;
				end
				// row count saturates on frame overrun
				if (srow != SRC_W'(SRC_MAX))
					srow_q <= srow + SRC_W'(1);
				else
					srow_q <= srow;
			end else begin
				scol_q <= scol + SRC_W'(1);
				srow_q <= srow;
				grow_q <= grow;
				racc_q <= racc;
				if (sel) begin
					gcol_q <= gcol + GCNT_W'(1);
					cacc_q <= cacc + ACC_W'(width_q);
				end else begin
					gcol_q <= gcol;
					cacc_q <= cacc;
				end
			end
		end
	end

endmodule

>>> sv/ndg_queue.sv
// ----------------------------------------------------------------------------
// ndg_queue
// Short first-in first-out queue of selected pixels between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  ndg_pkg::ndg_task_t  push_data,
	input  logic                pop,
	output ndg_pkg::ndg_task_t  head,
	output ndg_pkg::ndg_qstat_t qstat
);
	import ndg_pkg::*;

	ndg_task_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign qstat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push     = push_valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/ndg_back.sv
// ----------------------------------------------------------------------------
// ndg_back
// Converts queued pixels to signed gray and holds them in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ndg_pkg::ndg_task_t  head,
	input  ndg_pkg::ndg_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	output ndg_pkg::ndg_out_t   out_data,
	input  logic                out_stall
);
	import ndg_pkg::*;

	logic     out_valid_q;
	ndg_out_t out_q;

	// take a word when the output register is empty or being drained
	assign pop       = !qstat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.sample    <= to_sample(head.red, head.green, head.blue);
			out_q.out_col   <= head.col;
			out_q.out_row   <= head.row;
			out_q.frame_end <= head.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

endmodule

>>> sv/nearest_downscale_gray_int8_core.sv
// ----------------------------------------------------------------------------
// nearest_downscale_gray_int8_core
// Nearest-neighbor downscaler of an RGB888 raster to a 96x96 signed gray grid.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock with no bubbles while the queue is not full:
// the front computes its next counters and accumulators combinationally, so a
// new pixel can be accepted at every edge. A selected pixel enters a four-word
// queue at its accept edge and then the output register, out of which its
// result is valid; pixels that fall between grid points give no result. The
// input stalls only while the queue is full, which takes a stalled output.
// Source sizes must be written on the configuration port (index 0 width,
// 1 height) only while no frame is streaming; the block does not enforce it.
`timescale 1ns / 1ps

`include "nearest_downscale_gray_int8_core_assert.svh"

module nearest_downscale_gray_int8_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ndg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndg_pkg::SRC_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  ndg_pkg::ndg_in_t              in_data,
	output logic                          in_stall,
	output logic                          out_valid,
	output ndg_pkg::ndg_out_t             out_data,
	input  logic                          out_stall
);
	import ndg_pkg::*;

	ndg_qstat_t qstat;
	ndg_task_t  push_data, head;
	logic       push_valid, pop;

	ndg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.in_stall   (in_stall),
		.qstat      (qstat),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	ndg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	ndg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

	// a selected word must never meet a full queue
	`NDG_NEVER(a_queue_no_overflow, clk, arst_n, push_valid && qstat.full, "queue overflow")

	// the first pixel of a frame always lands on grid point zero
	`NDG_ASSERT(a_frame_start_origin, clk, arst_n, (in_valid && !in_stall && in_data.frame_start) |-> (push_valid && push_data.col == '0 && push_data.row == '0), "frame start not at origin")

	// a delivered column stays inside the grid
	`NDG_ASSERT(a_out_col_range, clk, arst_n, out_valid |-> ({1'b0, out_data.out_col} < (COORD_W + 1)'(GRID_SIZE)) || (GRID_SIZE > (1 << COORD_W)), "column outside grid")

endmodule
